// File: hdl/pff_pkg.sv
// Shared types, constants and helper functions for the probe frame filter.
`default_nettype none
package pff_pkg;

    // Frame layout and limits
    localparam logic [15:0] POS_MAX    = 16'hFFFF;
    localparam logic [15:0] HDR_LIMIT  = 16'd1000;
    localparam logic [15:0] HDR_MIN    = 16'd4;
    localparam logic [15:0] ADDR_START = 16'd4;
    localparam logic [15:0] ADDR_END   = 16'd21;
    localparam logic [7:0]  FC_TYPE_MASK = 8'h0C;
    localparam logic [3:0]  STYPE_REQ  = 4'h4;
    localparam logic [3:0]  STYPE_RESP = 4'h5;

    // Timer
    localparam int TICK_WIDTH = 32;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

    // Event queue between parser and timer
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Stream widths
    localparam int MAC_W     = 48;
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_REQ  = 2'd1,
        KIND_RESP = 2'd2
    } t_kind;

    // One queue entry: a tick, or the verdict of a finished frame
    typedef struct packed {
        logic  is_tick;
        t_kind kind;
    } t_evt;

    typedef struct packed {
        logic [15:0] pos;
        logic [15:0] hlen;
        logic [7:0]  ctrl;
        logic        rej;
        logic [2:0]  match;
    } t_frame_st;

    localparam t_frame_st FRAME_FRESH = '{
        pos: 16'd0, hlen: 16'd0, ctrl: 8'd0, rej: 1'b0, match: 3'b111
    };

    typedef struct packed {
        logic [1:0] a;   // which address field
        logic [2:0] b;   // byte within that field
    } t_slot;

    // Map a byte offset within the three address fields to field and byte.
    function automatic t_slot addr_slot(input logic [4:0] x);
        t_slot s;
        if (x >= 5'd12) begin
            s.a = 2'd2;
            s.b = 3'(x - 5'd12);
        end else if (x >= 5'd6) begin
            s.a = 2'd1;
            s.b = 3'(x - 5'd6);
        end else begin
            s.a = 2'd0;
            s.b = 3'(x);
        end
        return s;
    endfunction

    // First byte on the air sits in the top byte of the address.
    function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac,
                                            input logic [2:0] b);
        logic [7:0] v;
        case (b)
            3'd0:    v = mac[47:40];
            3'd1:    v = mac[39:32];
            3'd2:    v = mac[31:24];
            3'd3:    v = mac[23:16];
            3'd4:    v = mac[15:8];
            3'd5:    v = mac[7:0];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/pff_front.sv
// Byte parser: checks the radiotap preamble, decodes the frame and queues verdicts and ticks.
`default_nettype none
module pff_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wen,
    input  wire logic [pff_pkg::MAC_W-1:0] i_cfg_wdata,
    input  wire logic                      i_valid,
    input  wire logic                      i_opcode,
    input  wire logic [7:0]                i_data,
    input  wire logic                      i_first,
    input  wire logic                      i_last,
    output logic                           o_ready,
    input  wire logic                      i_q_full,
    output logic                           o_push,
    output pff_pkg::t_evt                  o_push_evt
);
    import pff_pkg::*;

    logic [MAC_W-1:0] r_mac;
    t_frame_st        r_fr;
    t_frame_st        n_fr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac <= '0;
            r_fr  <= FRAME_FRESH;
        end else begin
            if (i_cfg_wen) begin
                r_mac <= i_cfg_wdata;
            end
            r_fr <= n_fr;
        end
    end

    assign o_ready = !i_q_full;

    always_comb begin
        t_frame_st   base;
        t_frame_st   upd;
        logic [15:0] idx;
        logic [15:0] h3;
        logic [15:0] off;
        t_slot       sl;
        logic [16:0] addr_end;
        logic        ok;
        t_kind       kind;

        base = i_first ? FRAME_FRESH : r_fr;
        upd  = base;
        idx  = base.pos;
        h3   = {i_data, base.hlen[7:0]};
        off  = idx - base.hlen;
        sl   = addr_slot(5'(off - ADDR_START));

        if (idx != POS_MAX) begin
            upd.pos = idx + 16'd1;
            case (idx)
                16'd0, 16'd1: begin
                    if (i_data != 8'h00) begin
                        upd.rej = 1'b1;
                    end
                end
                16'd2: begin
                    upd.hlen = {8'h00, i_data};
                end
                16'd3: begin
                    upd.hlen = h3;
                    if (h3 > HDR_LIMIT || h3 < HDR_MIN) begin
                        upd.rej = 1'b1;
                    end
                end
                default: begin
                    if (idx >= base.hlen) begin
                        if (off == 16'd0) begin
                            upd.ctrl = i_data;
                            if ((i_data & FC_TYPE_MASK) != 8'h00 ||
                                (i_data[7:4] != STYPE_REQ && i_data[7:4] != STYPE_RESP)) begin
                                upd.rej = 1'b1;
                            end
                        end else if (off >= ADDR_START && off <= ADDR_END) begin
                            if (i_data != mac_byte(r_mac, sl.b)) begin
                                upd.match[sl.a] = 1'b0;
                            end
                        end
                    end
                end
            endcase
        end

        // addr3 must end inside the saturating position range and no later than the last byte
        addr_end = {1'b0, upd.hlen} + {1'b0, ADDR_END};
        ok = !upd.rej && (addr_end < {1'b0, POS_MAX}) && ({1'b0, idx} >= addr_end)
             && (upd.match != 3'b000);

        kind = KIND_NONE;
        if (ok) begin
            case (upd.ctrl[7:4])
                STYPE_REQ:  kind = KIND_REQ;
                STYPE_RESP: kind = KIND_RESP;
                default:    kind = KIND_NONE;
            endcase
        end

        n_fr       = r_fr;
        o_push     = 1'b0;
        o_push_evt = '{is_tick: 1'b1, kind: KIND_NONE};
        if (i_valid && !i_q_full) begin
            if (i_opcode == OP_TICK) begin
                o_push = 1'b1;
            end else if (i_last) begin
                // close the frame and queue its verdict
                n_fr       = FRAME_FRESH;
                o_push     = 1'b1;
                o_push_evt = '{is_tick: 1'b0, kind: kind};
            end else begin
                n_fr = upd;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/pff_fifo.sv
// Short event queue between the parser and the timer.
`default_nettype none
module pff_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pff_pkg::t_evt i_push_evt,
    output logic               o_full,
    output logic               o_valid,
    output pff_pkg::t_evt      o_head,
    input  wire logic          i_pop
);
    import pff_pkg::*;

    t_evt              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/pff_back.sv
// Tick timer and result register: applies queued events in order.
`default_nettype none
module pff_back (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_valid,
    input  wire pff_pkg::t_evt i_q_head,
    output logic          o_pop,
    input  wire logic     i_m_tready,
    output logic          o_m_tvalid,
    output pff_pkg::t_kind o_kind,
    output logic [31:0]   o_delay,
    output logic          o_req_seen
);
    import pff_pkg::*;

    logic [TICK_WIDTH-1:0] r_elapsed;
    logic [TICK_WIDTH-1:0] n_elapsed;
    logic                  r_req;
    logic                  n_req;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_kind                 r_kind;
    t_kind                 n_kind;
    logic [31:0]           r_delay;
    logic [31:0]           n_delay;
    logic                  r_seen;
    logic                  n_seen;
    logic [63:0]           elapsed_ext;
    logic [31:0]           elapsed_sat;
    logic                  out_free;

    assign elapsed_ext = 64'(r_elapsed);
    assign elapsed_sat = (elapsed_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                  : elapsed_ext[31:0];
    assign out_free    = !r_out_valid || i_m_tready;
    // ticks never wait on the output side
    assign o_pop       = i_q_valid && (i_q_head.is_tick || out_free);

    always_comb begin
        n_elapsed   = r_elapsed;
        n_req       = r_req;
        n_out_valid = r_out_valid && !i_m_tready;
        n_kind      = r_kind;
        n_delay     = r_delay;
        n_seen      = r_seen;
        if (o_pop) begin
            if (i_q_head.is_tick) begin
                if (r_elapsed != TICK_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end else begin
                n_out_valid = 1'b1;
                case (i_q_head.kind)
                    KIND_REQ: begin
                        n_elapsed = '0;
                        n_req     = 1'b1;
                        n_kind    = KIND_REQ;
                        n_delay   = 32'd0;
                        n_seen    = 1'b1;
                    end
                    KIND_RESP: begin
                        n_kind  = KIND_RESP;
                        n_delay = elapsed_sat;
                        n_seen  = r_req;
                    end
                    default: begin
                        n_kind  = KIND_NONE;
                        n_delay = 32'd0;
                        n_seen  = r_req;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed   <= '0;
            r_req       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_elapsed   <= n_elapsed;
            r_req       <= n_req;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_delay <= n_delay;
        r_seen  <= n_seen;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_kind     = r_kind;
    assign o_delay    = r_delay;
    assign o_req_seen = r_seen;

endmodule
`default_nettype wire

// File: hdl/probe_frame_filter_timer.sv
// Top level: probe request/response filter with response timer.
// Throughput: one byte or tick per cycle; the parser takes a transaction every cycle
// while the four-entry event queue has room.
// Results: a frame's verdict is written into the queue when its last byte is accepted,
// then the timer and result register take it from the queue head once nothing waits ahead
// of it and the output is free; ticks and non-final bytes give no result.
// Reset (synchronous, active low) clears the parser, queue, timer and station address.
`default_nettype none
module probe_frame_filter_timer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wen,
    input  wire logic [pff_pkg::MAC_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [pff_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic [pff_pkg::S_TUSER_W-1:0] i_s_axis_tuser,  // [0] opcode, [1] first_byte
    input  wire logic                          i_s_axis_tlast,  // last_byte
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [pff_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,  // [31:0] delay_ticks,
                                                                // [32] request_seen
    output logic [pff_pkg::M_TUSER_W-1:0]      o_m_axis_tuser   // [1:0] frame_kind
);
    import pff_pkg::*;

    logic        q_full;
    logic        q_push;
    t_evt        q_push_evt;
    logic        q_valid;
    t_evt        q_head;
    logic        q_pop;
    t_kind       out_kind;
    logic [31:0] out_delay;
    logic        out_seen;

    pff_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_s_axis_tvalid),
        .i_opcode   (i_s_axis_tuser[0]),
        .i_data     (i_s_axis_tdata),
        .i_first    (i_s_axis_tuser[1]),
        .i_last     (i_s_axis_tlast),
        .o_ready    (o_s_axis_tready),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_push_evt (q_push_evt)
    );

    pff_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_push_evt(q_push_evt),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_head    (q_head),
        .i_pop     (q_pop)
    );

    pff_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .i_m_tready(i_m_axis_tready),
        .o_m_tvalid(o_m_axis_tvalid),
        .o_kind    (out_kind),
        .o_delay   (out_delay),
        .o_req_seen(out_seen)
    );

    assign o_m_axis_tdata = {7'd0, out_seen, out_delay};
    assign o_m_axis_tuser = out_kind;

endmodule
`default_nettype wire

// File: hdl/pff_checker.sv
// Port-level checker for the probe frame filter, bound to the top level.
`default_nettype none
module pff_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);
    import pff_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_req_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_REQ |->
            o_m_axis_tdata[32] && o_m_axis_tdata[31:0] == 32'd0)
        else $error("request result without flag or with delay");

    a_none_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_NONE |-> o_m_axis_tdata[31:0] == 32'd0)
        else $error("rejected frame reports a delay");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != 2'd3 && o_m_axis_tdata[39:33] == 7'd0)
        else $error("bad result encoding");

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind probe_frame_filter_timer pff_checker u_pff_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the probe frame filter with response timer.
`timescale 1ns / 1ps
module testbench;
    import pff_pkg::*;

    localparam int IDLE_PCT     = 9;
    localparam int SETTLE_CYCLES = 16;
    localparam longint RUN_LIMIT_NS = 64'd400_000;

    typedef struct {
        t_kind       kind;
        logic [31:0] delay;
        logic        seen;
    } t_verdict;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wen;
    logic [MAC_W-1:0]     i_cfg_wdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;   // [7:0] data_byte
    logic [S_TUSER_W-1:0] i_s_axis_tuser;   // [0] opcode, [1] first_byte
    logic                 i_s_axis_tlast;   // last_byte
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;   // [31:0] delay_ticks, [32] request_seen
    logic [M_TUSER_W-1:0] o_m_axis_tuser;   // [1:0] frame_kind

    probe_frame_filter_timer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Filter state mirrored for prediction
    logic [MAC_W-1:0]      sta_mac = '0;
    t_frame_st             fr = FRAME_FRESH;
    logic [TICK_WIDTH-1:0] tick_count = '0;
    logic                  req_seen = 1'b0;

    t_verdict   verdict_q[$];
    t_verdict   head_verdict;
    logic [7:0] frame_buf[$];

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  frames_closed = 0;
    int  hold_request  = 0;
    int  hold_left     = 0;
    bit  no_idle       = 1'b0;

    task automatic report_mismatch(input string msg);
        if (mismatches < 50)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Decode one byte at frame index idx.
    task automatic decode_frame_byte(input int unsigned idx, input logic [7:0] d);
        int unsigned h, o, a, b;
        logic [7:0]  want;
        h = fr.hlen;
        if (idx <= 1) begin
            if (d != 8'd0) fr.rej = 1'b1;
        end else if (idx == 2) begin
            fr.hlen = {8'd0, d};
        end else if (idx == 3) begin
            h = fr.hlen | (int'(d) << 8);
            fr.hlen = h[15:0];
            if (h > HDR_LIMIT || h < HDR_MIN) fr.rej = 1'b1;
        end else if (idx >= h) begin
            o = idx - h;
            if (o == 0) begin
                fr.ctrl = d;
                if ((d & FC_TYPE_MASK) != 8'd0 || (d[7:4] != STYPE_REQ && d[7:4] != STYPE_RESP))
                    fr.rej = 1'b1;
            end else if (o >= ADDR_START && o <= ADDR_END) begin
                a = (o - ADDR_START) / 6;
                b = (o - ADDR_START) % 6;
                want = sta_mac[8*(5-b) +: 8];
                if (want != d) fr.match[a] = 1'b0;
            end
        end
    endtask

    // Advance the mirrored filter by one accepted transaction; queue a verdict on a last byte.
    task automatic classify_item(input t_opcode op, input logic [7:0] d,
                                 input logic first, input logic last);
        int unsigned idx, h;
        t_verdict    v;
        if (op == OP_TICK) begin
            if (tick_count != TICK_MAX) tick_count++;
        end else begin
            if (first) fr = FRAME_FRESH;
            idx = fr.pos;
            if (fr.pos != POS_MAX) begin
                decode_frame_byte(idx, d);
                fr.pos = fr.pos + 16'd1;
            end
            if (last) begin
                h = fr.hlen;
                v.kind  = KIND_NONE;
                v.delay = '0;
                if (!fr.rej && h + ADDR_END < POS_MAX && idx >= h + ADDR_END
                    && fr.match != 3'b000) begin
                    if (fr.ctrl[7:4] == STYPE_REQ) begin
                        v.kind = KIND_REQ;
                        tick_count = '0;
                        req_seen = 1'b1;
                    end else if (fr.ctrl[7:4] == STYPE_RESP) begin
                        v.kind  = KIND_RESP;
                        v.delay = (64'(tick_count) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                    : 32'(tick_count);
                    end
                end
                v.seen = req_seen;
                verdict_q.push_back(v);
                frames_closed++;
                fr = FRAME_FRESH;
            end
        end
    endtask

    // Offer one transaction; entered and left at a falling edge, tvalid left high.
    task automatic send_item(input t_opcode op, input logic [7:0] d,
                             input logic first, input logic last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tuser  <= {first, op};
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        classify_item(op, d, first, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_tick(input int n);
        repeat (n) send_item(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Fill frame_buf with a radiotap preamble, header, frame control, three addresses and a random tail.
    task automatic build_frame(input logic [7:0] fc, input int hl,
                               input logic [2:0] hit, input int tail);
        logic [15:0] len16;
        logic [7:0]  b;
        int          i, j, a, k;
        bit          wild;
        len16 = 16'(hl);
        frame_buf.delete();
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(len16[7:0]);
        frame_buf.push_back(len16[15:8]);
        for (i = 4; i < hl; i++) frame_buf.push_back(8'($urandom));
        frame_buf.push_back(fc);
        repeat (3) frame_buf.push_back(8'($urandom));
        for (a = 0; a < 3; a++) begin
            k = $urandom_range(0, 5);
            wild = 1'($urandom);
            for (j = 0; j < 6; j++) begin
                b = sta_mac[8*(5-j) +: 8];
                // Break a non-hit address fully, or in one byte only
                if (!hit[a]) begin
                    if (wild) b = 8'($urandom);
                    else if (j == k) b = b ^ 8'($urandom_range(1, 255));
                end
                frame_buf.push_back(b);
            end
        end
        repeat (tail) frame_buf.push_back(8'($urandom));
    endtask

    task automatic send_frame(input bit mark_first, input int tick_pct);
        int i, n;
        n = frame_buf.size();
        for (i = 0; i < n; i++) begin
            if (tick_pct > 0 && $urandom_range(99) < tick_pct) send_tick($urandom_range(1, 3));
            send_item(OP_BYTE, frame_buf[i], mark_first && i == 0, i == n - 1);
        end
    endtask

    task automatic send_probe(input logic [3:0] st, input logic [2:0] hit, input bit mark_first);
        build_frame({st, 2'b00, 2'($urandom)}, $urandom_range(4, 8), hit, $urandom_range(0, 1));
        send_frame(mark_first, 0);
    endtask

    // Stop offering and wait for every expected verdict, then let the pipeline settle.
    task automatic wait_quiet();
        i_s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_station(input logic [MAC_W-1:0] m);
        wait_quiet();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        sta_mac = m;
    endtask

    task automatic test_after_reset();
        send_tick(3);
        // Response before any request, and no frame start mark after reset
        send_probe(STYPE_RESP, 3'b001, 1'b0);
        send_probe(STYPE_REQ, 3'b010, 1'b1);
        send_tick(5);
        send_probe(STYPE_RESP, 3'b100, 1'b0);
    endtask

    task automatic test_register_extremes();
        logic [MAC_W-1:0] pats[2];
        int               p;
        pats[0] = '1;
        pats[1] = '0;
        for (p = 0; p < 2; p++) begin
            write_station(pats[p]);
            send_probe(STYPE_REQ, 3'b111, 1'b1);
            send_tick(3);
            send_probe(STYPE_RESP, 3'(1 << p), 1'b0);
        end
    endtask

    task automatic test_frame_checks();
        logic [7:0]  fc;
        int          i, sel;
        write_station(rand_mac());
        // One-byte frames
        frame_buf.delete();
        frame_buf.push_back(8'h00);
        send_frame(1'b1, 0);
        frame_buf[0] = 8'hFF;
        send_frame(1'b1, 0);
        // Nonzero version byte
        build_frame({STYPE_REQ, 4'h0}, 4, 3'b111, 0);
        frame_buf[0] = 8'($urandom_range(1, 255));
        send_frame(1'b1, 0);
        // Radiotap length below the minimum, then at the minimum
        build_frame({STYPE_REQ, 4'h0}, 4, 3'b111, 0);
        frame_buf[2] = 8'd3;
        frame_buf[3] = 8'd0;
        send_frame(1'b1, 0);
        build_frame({STYPE_RESP, 4'h0}, HDR_MIN, 3'b001, 0);
        send_frame(1'b1, 0);
        // Type bits set on a probe request subtype
        fc = {STYPE_REQ, 2'($urandom_range(1, 3)), 2'b00};
        build_frame(fc, 4, 3'b111, 0);
        send_frame(1'b1, 0);
        // Another management subtype
        sel = $urandom_range(13);
        fc = {((sel < 4) ? 4'(sel) : 4'(sel + 2)), 4'h0};
        build_frame(fc, 4, 3'b111, 0);
        send_frame(1'b1, 0);
        // Short frame: one byte short of addr3, then exactly to its end
        build_frame({STYPE_REQ, 4'h0}, 4, 3'b100, 0);
        frame_buf.delete(frame_buf.size() - 1);
        send_frame(1'b1, 0);
        build_frame({STYPE_REQ, 4'h0}, 4, 3'b100, 0);
        send_frame(1'b1, 0);
        // Abandoned frame restarted by a marked first byte
        for (i = 0; i < 5; i++) send_item(OP_BYTE, 8'($urandom), i == 0, 1'b0);
        send_probe(STYPE_RESP, 3'b010, 1'b1);
    endtask

    task automatic test_backpressure();
        wait_quiet();
        hold_request = 400;
        // Short frames and ticks pile up behind a stalled receiver
        repeat (24) begin
            frame_buf.delete();
            frame_buf.push_back(8'($urandom));
            send_frame(1'b1, 30);
        end
        wait_quiet();
        hold_request = 250;
        repeat (2) begin
            build_frame({(1'($urandom) ? STYPE_REQ : STYPE_RESP), 4'h0}, 4, 3'($urandom), 0);
            send_frame(1'b1, 20);
        end
        wait_quiet();
    endtask

    task automatic random_frame();
        int          r, sel, hl, cut, k, n;
        logic [7:0]  fc;
        logic [2:0]  hit;
        logic [15:0] len16;
        r   = $urandom_range(99);
        sel = $urandom_range(99);
        hl  = (sel < 90) ? $urandom_range(4, 8) : $urandom_range(9, 40);
        fc  = {(1'($urandom) ? STYPE_REQ : STYPE_RESP), 2'b00, 2'($urandom)};
        hit = ($urandom_range(3) == 0) ? 3'b000 : 3'($urandom_range(1, 7));
        if (r >= 70 && r < 80) fc = 8'($urandom);
        build_frame(fc, hl, hit, $urandom_range(0, 3));
        if (r >= 80 && r < 88) begin
            sel = $urandom_range(2);
            if (sel == 0) begin
                frame_buf[0] = 8'($urandom);
            end else if (sel == 1) begin
                frame_buf[1] = 8'($urandom);
            end else begin
                len16 = 16'($urandom);
                frame_buf[2] = len16[7:0];
                frame_buf[3] = len16[15:8];
            end
        end
        if (r >= 88 && r < 95) begin
            cut = $urandom_range(1, frame_buf.size());
            while (frame_buf.size() > cut) frame_buf.delete(frame_buf.size() - 1);
        end
        if (r >= 95) begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++)
                send_item(OP_BYTE, 8'($urandom), (k == 0) ? 1'($urandom) : 1'b0, 1'b0);
            send_frame(1'b1, 10);
        end else begin
            send_frame($urandom_range(99) < 80, 10);
        end
    endtask

    task automatic test_random();
        int phase, base_items, base_frames, min_items;
        for (phase = 0; phase < 4; phase++) begin
            write_station(rand_mac());
            no_idle = (phase == 2);
            if (phase == 3) hold_request = 200;
            min_items   = (phase == 2) ? 60 : 20;
            base_items  = items_sent;
            base_frames = frames_closed;
            while (items_sent - base_items < min_items || frames_closed - base_frames < 1)
                random_frame();
            no_idle = 1'b0;
        end
    endtask

    // Receiver: random stalls plus requested long hold-offs
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                head_verdict = verdict_q.pop_front();
                if (o_m_axis_tuser[1:0] !== head_verdict.kind)
                    report_mismatch($sformatf("frame_kind %0d, expected %0d",
                                              o_m_axis_tuser[1:0], head_verdict.kind));
                if (o_m_axis_tdata[31:0] !== head_verdict.delay)
                    report_mismatch($sformatf("delay_ticks %0d, expected %0d",
                                              o_m_axis_tdata[31:0], head_verdict.delay));
                if (o_m_axis_tdata[32] !== head_verdict.seen)
                    report_mismatch($sformatf("request_seen %b, expected %b",
                                              o_m_axis_tdata[32], head_verdict.seen));
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_wen       <= 1'b0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_m_axis_tready <= 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_after_reset();
        test_register_extremes();
        test_frame_checks();
        test_backpressure();
        test_random();
        wait_quiet();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
